/* design/iirl_pkg.sv */
// Package for the indexed insert/remove list: codes, field widths and the
// control word broadcast along the cell chain. No dependencies.
package iirl_pkg;

   localparam int CAPACITY_DEF  = 64;
   localparam int WORD_BITS_DEF = 32;

   localparam int KIND_BITS     = 2;
   localparam int POS_BITS      = 7;
   localparam int FIELD_BITS    = 32;
   localparam int STATUS_BITS   = 2;
   localparam int LENGTH_BITS   = 7;
   localparam int EXT_BITS      = 64;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_INSERT  = 2'd0,
      KIND_REMOVE  = 2'd1,
      KIND_READ    = 2'd2,
      KIND_REPLACE = 2'd3
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD    = 2'd0,
      OP_INSERT  = 2'd1,
      OP_REMOVE  = 2'd2,
      OP_REPLACE = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type          op;
      logic [POS_BITS-1:0]  position;
   } cell_ctrl_type;

endpackage

/* design/iirl_cell.sv */
// One list entry of the shift chain: takes from the lower or upper neighbour
// or the broadcast word as the control word says. Depends on iirl_pkg.
module iirl_cell #(
   parameter int INDEX     = 0,
   parameter int WORD_BITS = iirl_pkg::WORD_BITS_DEF
) (
   input  logic                    clock,
   input  iirl_pkg::cell_ctrl_type ctrl,
   input  logic [WORD_BITS-1:0]    new_word,
   input  logic [WORD_BITS-1:0]    lower_word,
   input  logic [WORD_BITS-1:0]    upper_word,
   output logic [WORD_BITS-1:0]    data,
   output logic [WORD_BITS-1:0]    tap
);
   import iirl_pkg::*;

   localparam logic [31:0] IndexVal = 32'(INDEX);

   logic [WORD_BITS-1:0] data_ff;
   logic [WORD_BITS-1:0] data_in;
   logic [31:0]          pos_wide;
   logic                 hit;
   logic                 above;

   assign pos_wide = 32'(ctrl.position);
   assign hit      = (IndexVal == pos_wide);
   assign above    = (IndexVal > pos_wide);

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (above) begin
               data_in = lower_word;
            end else if (hit) begin
               data_in = new_word;
            end
         end
         OP_REMOVE: begin
            if (above || hit) begin
               data_in = upper_word;
            end
         end
         OP_REPLACE: begin
            if (hit) begin
               data_in = new_word;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign tap  = hit ? data_ff : '0;

endmodule

/* design/indexed_insert_remove_list_top.sv */
// Top level of the indexed insert/remove list: request decode, count and
// response register around a chain of iirl_cell. Depends on iirl_pkg.
//
// Usage:
//   Request words enter on req_* (tuser = kind, tdata = position, word).
//   Each request inserts, removes, reads or replaces the entry at position.
//   One response word leaves on rsp_* per request (tuser = status,
//   tdata = value, length after the request).
//   rsp_tvalid rises in the cycle after a request is accepted.
//   One request is taken per cycle while the receiver keeps up: every cell
//   compares its own index with the position and shifts in the same cycle,
//   and the read value is an OR over the cell taps.
//   req_tready is high while the response register is empty or being
//   drained, so a stalled receiver holds one response and stops intake.
//   Reset empties the list (count zero) and drops any pending response;
//   entry contents are not cleared.
//   Errors (bad position, full list) leave the list unchanged and return
//   value zero.
module indexed_insert_remove_list_top #(
   parameter int CAPACITY  = iirl_pkg::CAPACITY_DEF,
   parameter int WORD_BITS = iirl_pkg::WORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // kind[1:0]
   input  logic [39:0] req_tdata,   // position[6:0], word[38:7], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic [39:0] rsp_tdata    // value[31:0], length[38:32], zero pad
);
   import iirl_pkg::*;

   localparam int CntBits = $clog2(CAPACITY + 1);
   localparam int CmpBits = (CntBits > POS_BITS) ? CntBits : POS_BITS;
   localparam logic [CntBits-1:0] CapVal = CntBits'(CAPACITY);

   kind_type               req_kind;
   logic [POS_BITS-1:0]    req_pos;
   logic [FIELD_BITS-1:0]  req_word;
   logic [EXT_BITS-1:0]    word_ext;
   logic [WORD_BITS-1:0]   new_word;
   logic                   accept;

   logic [CntBits-1:0]     count_ff;
   logic [CntBits-1:0]     count_in;
   logic [CmpBits-1:0]     pos_cmp;
   logic [CmpBits-1:0]     count_cmp;

   status_type             status;
   cell_ctrl_type          ctrl;
   logic [WORD_BITS-1:0]   rd_word;
   logic [EXT_BITS-1:0]    rd_ext;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [FIELD_BITS-1:0]  rsp_value_ff;
   logic [LENGTH_BITS-1:0] rsp_length_ff;
   status_type             rsp_status_ff;

   logic [WORD_BITS-1:0]   cell_data [CAPACITY];
   logic [WORD_BITS-1:0]   cell_tap  [CAPACITY];

   assign req_kind = kind_type'(req_tuser);
   assign req_pos  = req_tdata[POS_BITS-1:0];
   assign req_word = req_tdata[POS_BITS+FIELD_BITS-1:POS_BITS];
   assign word_ext = EXT_BITS'(req_word);
   assign new_word = word_ext[WORD_BITS-1:0];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign pos_cmp   = CmpBits'(req_pos);
   assign count_cmp = CmpBits'(count_ff);

   always_comb begin
      status   = ST_OK;
      ctrl.op  = OP_HOLD;
      ctrl.position = req_pos;
      count_in = count_ff;
      unique case (req_kind)
         KIND_INSERT: begin
            if (pos_cmp > count_cmp) begin
               status = ST_RANGE;
            end else if (count_ff == CapVal) begin
               status = ST_FULL;
            end else begin
               ctrl.op  = OP_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         KIND_REMOVE: begin
            if (pos_cmp >= count_cmp) begin
               status = ST_RANGE;
            end else begin
               ctrl.op  = OP_REMOVE;
               count_in = count_ff - 1'b1;
            end
         end
         KIND_READ: begin
            if (pos_cmp >= count_cmp) begin
               status = ST_RANGE;
            end
         end
         KIND_REPLACE: begin
            if (pos_cmp >= count_cmp) begin
               status = ST_RANGE;
            end else begin
               ctrl.op = OP_REPLACE;
            end
         end
         default: status = ST_OK;
      endcase
      if (!accept) begin
         ctrl.op  = OP_HOLD;
         count_in = count_ff;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_BITS-1:0] lower_word;
      logic [WORD_BITS-1:0] upper_word;
      if (i == 0) begin : g_first
         assign lower_word = new_word;
      end else begin : g_mid_lo
         assign lower_word = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign upper_word = cell_data[i];
      end else begin : g_mid_hi
         assign upper_word = cell_data[i+1];
      end
      iirl_cell #(
         .INDEX     (i),
         .WORD_BITS (WORD_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .new_word   (new_word),
         .lower_word (lower_word),
         .upper_word (upper_word),
         .data       (cell_data[i]),
         .tap        (cell_tap[i])
      );
   end

   always_comb begin
      rd_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_word = rd_word | cell_tap[i];
      end
   end

   assign rd_ext = EXT_BITS'(rd_word);

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status;
         rsp_length_ff <= LENGTH_BITS'(count_in);
         if (status == ST_OK && req_kind != KIND_INSERT) begin
            rsp_value_ff <= rd_ext[FIELD_BITS-1:0];
         end else begin
            rsp_value_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_length_ff, rsp_value_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CapVal)
      else $error("list count beyond capacity");

   a_error_keeps_count: assert property (@(posedge clock) disable iff (reset)
      accept && status != ST_OK |=> count_ff == $past(count_ff))
      else $error("count changed on a rejected request");

   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_value_ff == '0)
      else $error("non-zero value on an error response");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && status == ST_OK && req_kind == KIND_INSERT
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the list");

endmodule
